/* rtl/core/hsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hsa_pkg: shared types and codes of the handle slot allocator
// Request and response payloads, request kinds, status codes and the
// default sizing of the slot table.
// ---------------------------------------------------------------------------
package hsa_pkg;

	// Field widths of the request and response payloads
	localparam int HANDLE_BITS = 10;
	localparam int OBJECT_BITS = 32;
	localparam int COUNT_BITS  = 10;

	// Default sizing of the slot table
	localparam int DEF_CAPACITY   = 1024;
	localparam int DEF_VALUE_BITS = 32;

	// Request kinds
	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_GET    = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_SPARE  = 2'd3
	} req_kind_t;

	// Response status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_NULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]             req_type;
		logic [HANDLE_BITS-1:0] handle;
		logic [OBJECT_BITS-1:0] object_value;
	} req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [HANDLE_BITS-1:0] handle_out;
		logic [OBJECT_BITS-1:0] value_out;
		logic [COUNT_BITS-1:0]  live_count;
	} rsp_t;

endpackage
`default_nettype wire

/* rtl/core/hsa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hsa_ram: simple dual-port synchronous memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module hsa_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	parameter int AW    = 10
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/handle_slot_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted request is captured together with its memory reads, then the
// update is made and the response registered, held back while the response is stalled.
// Requests: a new request is not taken while one is in flight; the memory read and its
// write-back take turns, and the next request is held until the update has been made.
// Reset: counters return to empty at once; the slot table needs no clearing pass, as a
// slot at or above the high-water mark reads as empty. Requests are taken from reset.
// ---------------------------------------------------------------------------
// handle_slot_allocator: handle table with a free stack
// Insert takes a freed handle or the next fresh slot and stores the value;
// get reads it; remove clears the slot and pushes its handle for reuse.
// ---------------------------------------------------------------------------
module handle_slot_allocator #(
	parameter int CAPACITY   = hsa_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = hsa_pkg::DEF_VALUE_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire hsa_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output hsa_pkg::rsp_t      rsp
);

	localparam int SLOT_BITS = $clog2(CAPACITY);
	localparam int WIDE_BITS = 17;
	localparam logic [SLOT_BITS:0]     FRESH_LIMIT = (SLOT_BITS+1)'(CAPACITY);
	localparam logic [SLOT_BITS-1:0]   STACK_MAX   = SLOT_BITS'(CAPACITY - 1);
	localparam logic [SLOT_BITS:0]     FRESH_FIRST = (SLOT_BITS+1)'(1);

	// Allocation state
	logic [SLOT_BITS-1:0] free_depth_q;
	logic [SLOT_BITS:0]   next_fresh_q;
	logic [SLOT_BITS-1:0] occupied_q;

	// Request in flight, waiting for its memory reads
	logic                         valid_s1;
	logic [1:0]                   kind_s1;
	logic [hsa_pkg::HANDLE_BITS-1:0] handle_s1;
	logic [SLOT_BITS-1:0]         hidx_s1;
	logic                         written_s1;
	logic [VALUE_BITS-1:0]        val_s1;

	// Response register
	logic          rsp_valid_q;
	hsa_pkg::rsp_t rsp_q;

	logic accept;
	logic fire;

	// Memory ports
	logic                  slot_we;
	logic [SLOT_BITS-1:0]  slot_waddr;
	logic [VALUE_BITS-1:0] slot_wdata;
	logic [SLOT_BITS-1:0]  slot_raddr;
	logic [VALUE_BITS-1:0] slot_rd;
	logic                  stk_we;
	logic [SLOT_BITS-1:0]  stk_raddr;
	logic [SLOT_BITS-1:0]  stk_rd;

	// Request decode at the input
	logic [WIDE_BITS-1:0] handle_wide;
	logic [WIDE_BITS-1:0] fresh_wide;
	logic [63:0]          obj_wide;

	// Next state and response fields
	logic [SLOT_BITS-1:0]  free_depth_d;
	logic [SLOT_BITS:0]    next_fresh_d;
	logic [SLOT_BITS-1:0]  occupied_d;
	logic [1:0]            status_d;
	logic                  give_slot;
	logic                  give_value;
	logic [SLOT_BITS-1:0]  slot_sel;
	logic [WIDE_BITS-1:0]  slot_ext;
	logic [WIDE_BITS-1:0]  occ_ext;
	logic [63:0]           val_ext;
	hsa_pkg::rsp_t         rsp_d;

	// Hold the next request while one is in flight
	assign req_stall = valid_s1;
	assign accept    = req_valid && !valid_s1;
	assign fire      = valid_s1 && (!rsp_valid_q || !rsp_stall);

	assign handle_wide = WIDE_BITS'(req.handle);
	assign fresh_wide  = WIDE_BITS'(next_fresh_q);
	assign obj_wide    = 64'(req.object_value);

	// Read addresses: slot at the handle, stack at its top
	assign slot_raddr = handle_wide[SLOT_BITS-1:0];
	assign stk_raddr  = (free_depth_q == '0) ? '0 : free_depth_q - SLOT_BITS'(1);

	// Capture the request for the update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= req.req_type;
			handle_s1  <= req.handle;
			hidx_s1    <= handle_wide[SLOT_BITS-1:0];
			written_s1 <= (handle_wide < fresh_wide);
			val_s1     <= obj_wide[VALUE_BITS-1:0];
		end
	end

	// Work out the update and the response
	always_comb begin
		free_depth_d = free_depth_q;
		next_fresh_d = next_fresh_q;
		occupied_d   = occupied_q;
		status_d     = hsa_pkg::ST_OK;
		give_slot    = 1'b0;
		give_value   = 1'b0;
		slot_sel     = stk_rd;
		slot_we      = 1'b0;
		slot_waddr   = hidx_s1;
		slot_wdata   = '0;
		stk_we       = 1'b0;
		unique case (kind_s1)
			hsa_pkg::REQ_INSERT: begin
				give_slot = 1'b1;
				if (val_s1 == '0) begin
					status_d = hsa_pkg::ST_NULL;
				end else if (free_depth_q != '0) begin
					slot_sel     = stk_rd;
					free_depth_d = free_depth_q - SLOT_BITS'(1);
				end else if (next_fresh_q < FRESH_LIMIT) begin
					slot_sel     = next_fresh_q[SLOT_BITS-1:0];
					next_fresh_d = next_fresh_q + (SLOT_BITS+1)'(1);
				end else begin
					status_d = hsa_pkg::ST_FULL;
				end
				if (status_d == hsa_pkg::ST_OK) begin
					slot_we    = 1'b1;
					slot_waddr = slot_sel;
					slot_wdata = val_s1;
					occupied_d = occupied_q + SLOT_BITS'(1);
				end
			end
			hsa_pkg::REQ_GET, hsa_pkg::REQ_REMOVE: begin
				if (handle_s1 == '0) begin
					status_d = hsa_pkg::ST_NULL;
				end else if (!written_s1 || slot_rd == '0) begin
					status_d = hsa_pkg::ST_EMPTY;
				end else begin
					give_value = 1'b1;
					if (kind_s1 == hsa_pkg::REQ_REMOVE && free_depth_q < STACK_MAX) begin
						slot_we      = 1'b1;
						stk_we       = 1'b1;
						free_depth_d = free_depth_q + SLOT_BITS'(1);
						if (occupied_q != '0) begin
							occupied_d = occupied_q - SLOT_BITS'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Assemble the response fields
	assign slot_ext = WIDE_BITS'(slot_sel);
	assign occ_ext  = WIDE_BITS'(occupied_d);
	assign val_ext  = 64'(slot_rd);

	always_comb begin
		rsp_d            = '0;
		rsp_d.status     = status_d;
		rsp_d.live_count = occ_ext[hsa_pkg::COUNT_BITS-1:0];
		if (give_slot) begin
			rsp_d.handle_out = (status_d == hsa_pkg::ST_OK) ?
				slot_ext[hsa_pkg::HANDLE_BITS-1:0] : '0;
		end else begin
			rsp_d.handle_out = handle_s1;
		end
		if (give_value) begin
			rsp_d.value_out = val_ext[hsa_pkg::OBJECT_BITS-1:0];
		end
	end

	// Advance the allocation state when the update completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_depth_q <= '0;
			next_fresh_q <= FRESH_FIRST;
			occupied_q   <= '0;
		end else if (fire) begin
			free_depth_q <= free_depth_d;
			next_fresh_q <= next_fresh_d;
			occupied_q   <= occupied_d;
		end
	end

	// Response register: load on update, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Slot value table
	hsa_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_BITS),
		.AW    (SLOT_BITS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (fire && slot_we),
		.wr_addr (slot_waddr),
		.wr_data (slot_wdata),
		.rd_en   (accept),
		.rd_addr (slot_raddr),
		.rd_data (slot_rd)
	);

	// Free handle stack
	hsa_ram #(
		.DEPTH (CAPACITY - 1),
		.WIDTH (SLOT_BITS),
		.AW    (SLOT_BITS)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (fire && stk_we),
		.wr_addr (free_depth_q),
		.wr_data (hidx_s1),
		.rd_en   (accept),
		.rd_addr (stk_raddr),
		.rd_data (stk_rd)
	);

endmodule
`default_nettype wire

/* bench/hsa_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsa_checker: response checker for the handle slot allocator
// Watches both channels, keeps its own copy of the slot table, free stack and
// live count, predicts the response of every accepted request and compares
// the responses in order, field by field.
// ---------------------------------------------------------------------------
module hsa_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  hsa_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  hsa_pkg::rsp_t rsp,
	output int            mismatches,
	output int            pending
);
	import hsa_pkg::*;

	localparam int SLOTS = DEF_CAPACITY;

	// Shadow of the table: a zero entry is an empty slot
	logic [OBJECT_BITS-1:0] slot_val [SLOTS];
	logic [HANDLE_BITS-1:0] freed_handles [SLOTS-1];
	int                     free_top;
	int                     fresh_slot;
	int                     live;

	// Responses still owed by the block, oldest first
	rsp_t awaited_rsp [$];

	// Apply one request to the shadow table and return its response
	function automatic rsp_t apply_table_request(input req_t r);
		rsp_t p;
		int   slot;
		p = '0;
		p.handle_out = r.handle;
		slot = 0;
		case (req_kind_t'(r.req_type))
			REQ_INSERT: begin
				p.handle_out = '0;
				if (r.object_value == '0) begin
					// a zero value would read back as an empty slot
					p.status = ST_NULL;
				end else if (free_top > 0) begin
					// reuse the most recently freed handle
					free_top--;
					slot = freed_handles[free_top];
				end else if (fresh_slot < SLOTS) begin
					slot = fresh_slot;
					fresh_slot++;
				end else begin
					p.status = ST_FULL;
				end
				if (slot != 0) begin
					slot_val[slot] = r.object_value;
					live++;
					p.handle_out = HANDLE_BITS'(slot);
				end
			end
			REQ_GET, REQ_REMOVE: begin
				if (r.handle == '0) begin
					p.status = ST_NULL;
				end else if (slot_val[r.handle] == '0) begin
					p.status = ST_EMPTY;
				end else begin
					p.value_out = slot_val[r.handle];
					if (r.req_type == REQ_REMOVE) begin
						slot_val[r.handle] = '0;
						freed_handles[free_top] = r.handle;
						free_top++;
						live--;
					end
				end
			end
			default: ;
		endcase
		p.live_count = COUNT_BITS'(live);
		return p;
	endfunction

	// Compare one accepted response with the oldest prediction
	task automatic check_response(input rsp_t got);
		rsp_t want;
		if (awaited_rsp.size() == 0) begin
			$error("response with no request outstanding: handle_out %0d", got.handle_out);
			mismatches++;
		end else begin
			want = awaited_rsp.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatches++;
			end
			if (got.handle_out !== want.handle_out) begin
				$error("handle_out: expected %0d, actual %0d",
					want.handle_out, got.handle_out);
				mismatches++;
			end
			if (got.value_out !== want.value_out) begin
				$error("value_out: expected %h, actual %h", want.value_out, got.value_out);
				mismatches++;
			end
			if (got.live_count !== want.live_count) begin
				$error("live_count: expected %0d, actual %0d",
					want.live_count, got.live_count);
				mismatches++;
			end
		end
	endtask

	// Track the channels; a request is taken before a response at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (slot_val[i])
				slot_val[i] = '0;
			free_top   = 0;
			fresh_slot = 1;
			live       = 0;
			awaited_rsp.delete();
			pending <= 0;
		end else begin
			if (req_valid && !req_stall)
				awaited_rsp.push_back(apply_table_request(req));
			if (rsp_valid && !rsp_stall)
				check_response(rsp);
			pending <= awaited_rsp.size();
		end
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench top of the handle slot allocator
// Drives directed and random insert, get, remove and spare requests with random
// gaps and response stalls, churns a well filled table, and reports the
// verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module tb;
	import hsa_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   mismatches;
	int   pending;

	// Highest handle that an insert may have handed out so far
	int fresh_bound;
	// Requests still to go out back to back
	int burst_left;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	handle_slot_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	hsa_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Idle cycles after a request: mostly none or few, now and then long
	function automatic int sender_gap();
		int roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			burst_left = $urandom_range(20, 40);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Mostly handles that may be live, some null, some anywhere
	function automatic logic [HANDLE_BITS-1:0] pick_handle();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			return '0;
		if (roll < 16)
			return HANDLE_BITS'($urandom);
		return HANDLE_BITS'($urandom_range(1, fresh_bound));
	endfunction

	function automatic logic [OBJECT_BITS-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return '0;
		if (roll < 6)
			return '1;
		if (roll < 9)
			return OBJECT_BITS'(1);
		return OBJECT_BITS'($urandom);
	endfunction

	// Present one request, hold it until accepted, then idle for a drawn gap, if any
	task automatic issue_request(input req_kind_t kind, input logic [HANDLE_BITS-1:0] h,
			input logic [OBJECT_BITS-1:0] v);
		int gap;
		req_valid <= 1'b1;
		req <= '{req_type: kind, handle: h, object_value: v};
		do @(posedge clk); while (req_stall);
		if (kind == REQ_INSERT && fresh_bound < 1023)
			fresh_bound++;
		gap = sender_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off new requests until every response is back
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic run_mix(input int count, input int p_ins, input int p_get, input int p_rem);
		int        roll;
		req_kind_t kind;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < p_ins)
				kind = REQ_INSERT;
			else if (roll < p_ins + p_get)
				kind = REQ_GET;
			else if (roll < p_ins + p_get + p_rem)
				kind = REQ_REMOVE;
			else
				kind = REQ_SPARE;
			issue_request(kind, pick_handle(), pick_value());
		end
	endtask

	// Response side: runs of acceptance broken by stalls, a few of them long
	initial begin : rsp_side
		int run;
		int hold;
		int roll;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			roll = $urandom_range(0, 99);
			run  = (roll < 15) ? $urandom_range(30, 60) : $urandom_range(1, 6);
			roll = $urandom_range(0, 99);
			hold = (roll < 8) ? $urandom_range(10, 30) : $urandom_range(1, 3);
			repeat (run) @(posedge clk);
			rsp_stall <= 1'b1;
			repeat (hold) @(posedge clk);
			rsp_stall <= 1'b0;
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		fresh_bound = 4;
		burst_left  = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Null and never-written handles on an empty table
		issue_request(REQ_GET, '0, '0);
		issue_request(REQ_REMOVE, '0, '1);
		issue_request(REQ_GET, 10'd1, '0);
		issue_request(REQ_GET, '1, '0);
		issue_request(REQ_REMOVE, '1, '0);
		// A zero value is refused; then fill slots 1 to 3 with extreme values
		issue_request(REQ_INSERT, '0, '0);
		issue_request(REQ_INSERT, '1, '1);
		issue_request(REQ_INSERT, '0, 32'd1);
		issue_request(REQ_INSERT, 10'h155, 32'h8000_0000);
		issue_request(REQ_GET, 10'd1, '0);
		issue_request(REQ_GET, 10'd2, '0);
		// Remove twice: the second finds the slot empty
		issue_request(REQ_REMOVE, 10'd2, '0);
		issue_request(REQ_REMOVE, 10'd2, '0);
		issue_request(REQ_GET, 10'd2, '0);
		// Reuse of the freed handle, then last in first out over two frees
		issue_request(REQ_INSERT, '0, 32'h1234_5678);
		issue_request(REQ_REMOVE, 10'd3, '0);
		issue_request(REQ_REMOVE, 10'd1, '0);
		issue_request(REQ_INSERT, '1, 32'h5555_AAAA);
		issue_request(REQ_INSERT, '0, 32'hAAAA_5555);
		issue_request(REQ_GET, 10'd3, '0);
		// The spare request kind changes nothing
		issue_request(REQ_SPARE, '1, '1);
		issue_request(REQ_SPARE, '0, '0);
		wait_for_drain();

		// Mixed traffic on a lightly used table
		run_mix(150, 45, 30, 20);
		wait_for_drain();
		// Grow the table with mostly inserts, then churn it
		run_mix(150, 95, 3, 2);
		run_mix(80, 25, 25, 45);
		wait_for_drain();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#(5_000_000);
		$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/hsa_pkg.sv
rtl/core/hsa_ram.sv
rtl/core/handle_slot_allocator.sv
bench/hsa_checker.sv
bench/tb.sv
